// File: sv/ncnh_pkg.sv
// ----------------------------------------------------------------------------
// ncnh_pkg
// Shared types and constants of the neighbor cost next-hop selector.
// ----------------------------------------------------------------------------
package ncnh_pkg;

   // Divider operand widths: |txp| * weight_signal over |rssi|
   localparam int NUM_W    = 18;
   localparam int DEN_W    = 9;
   localparam int DIV_STEP = 4;
   localparam int DIV_CYC  = (NUM_W + DIV_STEP - 1) / DIV_STEP;
   localparam int DIV_W    = DIV_CYC * DIV_STEP;
   localparam int DCNT_W   = $clog2(DIV_CYC + 1);

   localparam int COST_W = 19;
   localparam logic signed [COST_W-1:0] COST_MAX = 19'sd262143;

   localparam logic [4:0] HOPS_EMPTY   = 5'd10;
   localparam logic [4:0] HOPS_GATEWAY = 5'd1;

   // Configuration register indexes
   localparam int CSR_W = 3;
   localparam logic [CSR_W-1:0] CSR_WEIGHT_SIGNAL    = 3'd0;
   localparam logic [CSR_W-1:0] CSR_WEIGHT_QUEUE     = 3'd1;
   localparam logic [CSR_W-1:0] CSR_WEIGHT_HOPS      = 3'd2;
   localparam logic [CSR_W-1:0] CSR_CONGESTION_LEVEL = 3'd3;
   localparam logic [CSR_W-1:0] CSR_TRANSMIT_POWER   = 3'd4;
   localparam logic [CSR_W-1:0] CSR_STALE_AFTER      = 3'd5;

   localparam logic OP_UPDATE = 1'b0;
   localparam logic OP_ROUTE  = 1'b1;

   typedef enum logic [1:0] {
      STATUS_UPDATED = 2'd0,
      STATUS_FULL    = 2'd1,
      STATUS_ROUTE   = 2'd2,
      STATUS_NONE    = 2'd3
   } status_type;

   typedef struct packed {
      logic [31:0]       address;
      logic signed [8:0] rssi;
      logic [3:0]        hops;
      logic [8:0]        queue;
      logic              online;
      logic [31:0]       last_seen;
   } entry_type;

   // Divider request from the sequencer
   typedef struct packed {
      logic             start;
      logic [NUM_W-1:0] dividend;
      logic [DEN_W-1:0] divisor;
   } div_req_type;

endpackage

// File: sv/ncnh_div.sv
// ----------------------------------------------------------------------------
// ncnh_div
// Iterative restoring divider, DIV_STEP quotient bits per cycle.
// ----------------------------------------------------------------------------
module ncnh_div
   import ncnh_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  div_req_type      req,
   output logic             done,
   output logic [NUM_W-1:0] quotient
);

   logic              busy_ff;
   logic              done_ff;
   logic [DCNT_W-1:0] cnt_ff;
   logic [DEN_W-1:0]  den_ff;
   logic [DEN_W-1:0]  rem_ff;
   logic [DEN_W-1:0]  rem_in;
   logic [DIV_W-1:0]  dq_ff;
   logic [DIV_W-1:0]  dq_in;

   always_comb begin
      logic [DEN_W:0]   trial;
      logic [DEN_W-1:0] r;
      logic [DIV_W-1:0] d;
      r = rem_ff;
      d = dq_ff;
      for (int k = 0; k < DIV_STEP; k++) begin
         trial = {r, d[DIV_W-1]};
         d = {d[DIV_W-2:0], 1'b0};
         if (trial >= {1'b0, den_ff}) begin
            trial = trial - {1'b0, den_ff};
            d[0] = 1'b1;
         end
         r = trial[DEN_W-1:0];
      end
      rem_in = r;
      dq_in  = d;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= DCNT_W'(DIV_CYC);
            den_ff  <= req.divisor;
            rem_ff  <= '0;
            dq_ff   <= DIV_W'(req.dividend);
         end else if (busy_ff) begin
            rem_ff <= rem_in;
            dq_ff  <= dq_in;
            cnt_ff <= cnt_ff - DCNT_W'(1);
            if (cnt_ff == DCNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = dq_ff[NUM_W-1:0];

endmodule

// File: sv/neighbor_cost_next_hop_selector.sv
// ----------------------------------------------------------------------------
// neighbor_cost_next_hop_selector
// Neighbor table with cost-based next-hop choice and gateway hop report.
// ----------------------------------------------------------------------------
// Input channel req_*: one beat is an update (op 0) or a route request (op 1).
// Result channel rsp_*: exactly one beat per input beat, in order.
// Configuration: csr_write with csr_index/csr_data, only while idle.
// The table lives in a single-port memory of TABLE_DEPTH entries that is
// read one slot at a time; a per-slot valid bit sits in flip-flops.
// Update: acceptance, an address-match scan (read and check states per
// slot), a write, a hop scan (read and check per slot) and a result state.
// Route request: one pass does purge, hop report and costing. A live slot
// with negative RSSI passes read, check, divider wait, sum and compare; a
// live slot with RSSI at or above zero passes read, check and compare; an
// empty or stale slot passes read and check only.
// req_stall is high from acceptance until the result is placed in the output
// register; the next beat is taken while that result still waits.
// A stalled result holds the output register and blocks the next result.
// Reset empties the table and loads the default configuration at once.
// ----------------------------------------------------------------------------
module neighbor_cost_next_hop_selector
   import ncnh_pkg::*;
#(
   parameter int TABLE_DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   // request channel
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_op,
   input  logic [31:0]              req_time_now,
   input  logic [31:0]              req_neighbor_address,
   input  logic signed [8:0]        req_rssi,
   input  logic [3:0]               req_hop_count,
   input  logic [8:0]               req_queue_fill,
   input  logic                     req_online_gateway,
   // result channel
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [1:0]               rsp_status,
   output logic [31:0]              rsp_next_hop,
   output logic signed [COST_W-1:0] rsp_route_cost,
   output logic                     rsp_congested,
   output logic                     rsp_fallback_used,
   output logic [4:0]               rsp_hops_to_gateway,
   // configuration
   input  logic                     csr_write,
   input  logic [CSR_W-1:0]         csr_index,
   input  logic [15:0]              csr_data
);

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_U_READ,
      ST_U_CHECK,
      ST_U_WRITE,
      ST_H_READ,
      ST_H_CHECK,
      ST_R_READ,
      ST_R_CHECK,
      ST_R_DIV,
      ST_R_SUM,
      ST_R_CMP,
      ST_DONE
   } state_type;

   // configuration registers
   logic [11:0]       weight_signal_ff;
   logic [11:0]       weight_queue_ff;
   logic [11:0]       weight_hops_ff;
   logic [8:0]        congestion_level_ff;
   logic signed [5:0] transmit_power_ff;
   logic [15:0]       stale_after_ff;

   // table
   entry_type        mem [TABLE_DEPTH];
   entry_type        rd_ff;
   entry_type        wr_data;
   logic             rd_en;
   logic             wr_en;
   logic [IDX_W-1:0] wr_idx;
   logic [TABLE_DEPTH-1:0] slot_valid_ff;

   // sequencer
   state_type        state_ff;
   logic [IDX_W-1:0] cnt_ff;
   logic             last_slot;
   logic             cur_valid;

   // latched request
   logic              op_ff;
   logic [31:0]       now_ff;
   logic [31:0]       addr_ff;
   logic signed [8:0] rssi_ff;
   logic [3:0]        hops_ff;
   logic [8:0]        queue_ff;
   logic              online_ff;
   logic [NUM_W-1:0]  num_ff;
   logic              neg_ff;

   // update search
   logic             match_found_ff;
   logic [IDX_W-1:0] match_idx_ff;
   logic             free_found_ff;
   logic [IDX_W-1:0] free_idx_ff;
   status_type       upd_status_ff;

   // hop report
   logic       hop_any_ff;
   logic       hop_gw_ff;
   logic [4:0] hop_min_ff;
   logic [4:0] hop_cand;
   logic [4:0] hop_result;

   // costing
   logic [12:0]             q_term_ff;
   logic [15:0]             h_term_ff;
   logic signed [COST_W-1:0] cost_ff;
   logic signed [COST_W-1:0] cost_sum;
   logic signed [COST_W-1:0] sig_term;
   logic [20:0]             q_prod;
   logic [15:0]             h_prod;
   logic [DEN_W-1:0]        rssi_mag;
   logic [5:0]              txp_mag;
   logic [NUM_W-1:0]        sig_num;
   logic [31:0]             age;
   logic                    stale;

   logic                     b1_found_ff;
   logic [31:0]              b1_addr_ff;
   logic signed [COST_W-1:0] b1_cost_ff;
   logic [8:0]               b1_queue_ff;
   logic                     b2_found_ff;
   logic [31:0]              b2_addr_ff;
   logic signed [COST_W-1:0] b2_cost_ff;

   // divider
   div_req_type      div_req;
   logic             div_done;
   logic [NUM_W-1:0] div_quot;

   // output register
   logic                     rsp_valid_ff;
   logic [1:0]               rsp_status_ff;
   logic [31:0]              rsp_next_hop_ff;
   logic signed [COST_W-1:0] rsp_route_cost_ff;
   logic                     rsp_congested_ff;
   logic                     rsp_fallback_ff;
   logic [4:0]               rsp_hops_ff;
   logic                     out_free;
   logic                     rsp_load;
   logic                     req_take;

   // result assembly
   logic [1:0]               res_status;
   logic [31:0]              res_next_hop;
   logic signed [COST_W-1:0] res_cost;
   logic                     res_congested;
   logic                     res_fallback;

   ncnh_div u_div (
      .clock    (clock),
      .reset    (reset),
      .req      (div_req),
      .done     (div_done),
      .quotient (div_quot)
   );

   // ---------------------------------------------------------------- config
   always_ff @(posedge clock) begin
      if (reset) begin
         weight_signal_ff    <= 12'd256;
         weight_queue_ff     <= 12'd256;
         weight_hops_ff      <= 12'd256;
         congestion_level_ff <= 9'd205;
         transmit_power_ff   <= 6'sd14;
         stale_after_ff      <= 16'd60;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_WEIGHT_SIGNAL:    weight_signal_ff    <= csr_data[11:0];
            CSR_WEIGHT_QUEUE:     weight_queue_ff     <= csr_data[11:0];
            CSR_WEIGHT_HOPS:      weight_hops_ff      <= csr_data[11:0];
            CSR_CONGESTION_LEVEL: congestion_level_ff <= csr_data[8:0];
            CSR_TRANSMIT_POWER:   transmit_power_ff   <= csr_data[5:0];
            CSR_STALE_AFTER:      stale_after_ff      <= csr_data;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------- memory
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_ff <= mem[cnt_ff];
      end
   end

   assign rd_en = (state_ff == ST_U_READ) || (state_ff == ST_H_READ) ||
                  (state_ff == ST_R_READ);
   assign wr_en  = (state_ff == ST_U_WRITE) && (match_found_ff || free_found_ff);
   assign wr_idx = match_found_ff ? match_idx_ff : free_idx_ff;

   always_comb begin
      wr_data.address   = addr_ff;
      wr_data.rssi      = rssi_ff;
      wr_data.hops      = hops_ff;
      wr_data.queue     = queue_ff;
      wr_data.online    = online_ff;
      wr_data.last_seen = now_ff;
   end

   // ------------------------------------------------------------ datapath
   assign last_slot = (cnt_ff == LAST_IDX);
   assign cur_valid = slot_valid_ff[cnt_ff];

   assign age   = now_ff - rd_ff.last_seen;
   assign stale = age > {16'd0, stale_after_ff};

   assign rssi_mag = ~rd_ff.rssi + DEN_W'(1);
   assign txp_mag  = transmit_power_ff[5] ? (~transmit_power_ff + 6'd1) : transmit_power_ff;
   assign sig_num  = weight_signal_ff * txp_mag;
   assign q_prod   = weight_queue_ff * rd_ff.queue;
   assign h_prod   = rd_ff.online ? 16'd0 : weight_hops_ff * rd_ff.hops;

   assign sig_term = neg_ff ? -$signed({1'b0, div_quot}) : $signed({1'b0, div_quot});
   assign cost_sum = sig_term + $signed({6'd0, q_term_ff}) + $signed({3'd0, h_term_ff});

   assign hop_cand = {1'b0, rd_ff.hops} + 5'd1;
   assign hop_result = hop_gw_ff ? HOPS_GATEWAY : (hop_any_ff ? hop_min_ff : HOPS_EMPTY);

   always_comb begin
      div_req.start    = (state_ff == ST_R_CHECK) && cur_valid && !stale && rd_ff.rssi[8];
      div_req.dividend = num_ff;
      div_req.divisor  = rssi_mag;
   end

   always_comb begin
      res_status    = upd_status_ff;
      res_next_hop  = '0;
      res_cost      = '0;
      res_congested = 1'b0;
      res_fallback  = 1'b0;
      if (op_ff == OP_ROUTE) begin
         if (!b1_found_ff) begin
            res_status = STATUS_NONE;
         end else begin
            res_status   = STATUS_ROUTE;
            res_next_hop = b1_addr_ff;
            res_cost     = b1_cost_ff;
            if (b1_queue_ff >= congestion_level_ff) begin
               res_congested = 1'b1;
               if (b2_found_ff) begin
                  res_next_hop = b2_addr_ff;
                  res_cost     = b2_cost_ff;
                  res_fallback = 1'b1;
               end
            end
         end
      end
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_load = (state_ff == ST_DONE) && out_free;
   assign req_take = (state_ff == ST_IDLE) && req_valid;

   // ------------------------------------------------------------ sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cnt_ff        <= '0;
         slot_valid_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  op_ff          <= req_op;
                  now_ff         <= req_time_now;
                  addr_ff        <= req_neighbor_address;
                  rssi_ff        <= req_rssi;
                  hops_ff        <= req_hop_count;
                  queue_ff       <= req_queue_fill;
                  online_ff      <= req_online_gateway;
                  num_ff         <= sig_num;
                  neg_ff         <= transmit_power_ff[5];
                  cnt_ff         <= '0;
                  match_found_ff <= 1'b0;
                  free_found_ff  <= 1'b0;
                  hop_any_ff     <= 1'b0;
                  hop_gw_ff      <= 1'b0;
                  b1_found_ff    <= 1'b0;
                  b2_found_ff    <= 1'b0;
                  state_ff       <= (req_op == OP_ROUTE) ? ST_R_READ : ST_U_READ;
               end
            end

            ST_U_READ: begin
               state_ff <= ST_U_CHECK;
            end

            ST_U_CHECK: begin
               if (cur_valid && (rd_ff.address == addr_ff) && !match_found_ff) begin
                  match_found_ff <= 1'b1;
                  match_idx_ff   <= cnt_ff;
               end
               if (!cur_valid && !free_found_ff) begin
                  free_found_ff <= 1'b1;
                  free_idx_ff   <= cnt_ff;
               end
               if (last_slot) begin
                  state_ff <= ST_U_WRITE;
               end else begin
                  cnt_ff   <= cnt_ff + IDX_W'(1);
                  state_ff <= ST_U_READ;
               end
            end

            ST_U_WRITE: begin
               if (match_found_ff || free_found_ff) begin
                  slot_valid_ff[wr_idx] <= 1'b1;
                  upd_status_ff         <= STATUS_UPDATED;
               end else begin
                  upd_status_ff <= STATUS_FULL;
               end
               cnt_ff   <= '0;
               state_ff <= ST_H_READ;
            end

            ST_H_READ: begin
               state_ff <= ST_H_CHECK;
            end

            ST_H_CHECK: begin
               if (cur_valid) begin
                  hop_any_ff <= 1'b1;
                  if (rd_ff.online) begin
                     hop_gw_ff <= 1'b1;
                  end
                  if (!hop_any_ff || hop_cand < hop_min_ff) begin
                     hop_min_ff <= hop_cand;
                  end
               end
               if (last_slot) begin
                  state_ff <= ST_DONE;
               end else begin
                  cnt_ff   <= cnt_ff + IDX_W'(1);
                  state_ff <= ST_H_READ;
               end
            end

            ST_R_READ: begin
               state_ff <= ST_R_CHECK;
            end

            ST_R_CHECK: begin
               if (cur_valid && stale) begin
                  slot_valid_ff[cnt_ff] <= 1'b0;
               end
               if (cur_valid && !stale) begin
                  // live slot: count it for the hop report, then cost it
                  hop_any_ff <= 1'b1;
                  if (rd_ff.online) begin
                     hop_gw_ff <= 1'b1;
                  end
                  if (!hop_any_ff || hop_cand < hop_min_ff) begin
                     hop_min_ff <= hop_cand;
                  end
                  q_term_ff <= q_prod[20:8];
                  h_term_ff <= h_prod;
                  if (rd_ff.rssi[8]) begin
                     state_ff <= ST_R_DIV;
                  end else begin
                     cost_ff  <= COST_MAX;
                     state_ff <= ST_R_CMP;
                  end
               end else if (last_slot) begin
                  state_ff <= ST_DONE;
               end else begin
                  cnt_ff   <= cnt_ff + IDX_W'(1);
                  state_ff <= ST_R_READ;
               end
            end

            ST_R_DIV: begin
               if (div_done) begin
                  state_ff <= ST_R_SUM;
               end
            end

            ST_R_SUM: begin
               cost_ff  <= cost_sum;
               state_ff <= ST_R_CMP;
            end

            ST_R_CMP: begin
               // strict compares keep the lower slot on ties
               if (!b1_found_ff || cost_ff < b1_cost_ff) begin
                  b2_found_ff <= b1_found_ff;
                  b2_addr_ff  <= b1_addr_ff;
                  b2_cost_ff  <= b1_cost_ff;
                  b1_found_ff <= 1'b1;
                  b1_addr_ff  <= rd_ff.address;
                  b1_cost_ff  <= cost_ff;
                  b1_queue_ff <= rd_ff.queue;
               end else if (!b2_found_ff || cost_ff < b2_cost_ff) begin
                  b2_found_ff <= 1'b1;
                  b2_addr_ff  <= rd_ff.address;
                  b2_cost_ff  <= cost_ff;
               end
               if (last_slot) begin
                  state_ff <= ST_DONE;
               end else begin
                  cnt_ff   <= cnt_ff + IDX_W'(1);
                  state_ff <= ST_R_READ;
               end
            end

            ST_DONE: begin
               // hold until the output register can take the beat
               if (out_free) begin
                  rsp_status_ff     <= res_status;
                  rsp_next_hop_ff   <= res_next_hop;
                  rsp_route_cost_ff <= res_cost;
                  rsp_congested_ff  <= res_congested;
                  rsp_fallback_ff   <= res_fallback;
                  rsp_hops_ff       <= hop_result;
                  state_ff          <= ST_IDLE;
               end
            end

            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_stall           = (state_ff != ST_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_next_hop        = rsp_next_hop_ff;
   assign rsp_route_cost      = rsp_route_cost_ff;
   assign rsp_congested       = rsp_congested_ff;
   assign rsp_fallback_used   = rsp_fallback_ff;
   assign rsp_hops_to_gateway = rsp_hops_ff;

   // ------------------------------------------------------------ assertions
   a_fallback_needs_congestion: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_fallback_used || rsp_congested))
      else $error("fallback reported without congestion");

   a_update_result_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == STATUS_UPDATED || rsp_status == STATUS_FULL)) |->
      (rsp_next_hop == 32'd0 && !rsp_congested && rsp_route_cost == '0))
      else $error("update result carries route fields");

   a_div_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_R_DIV))
      else $error("divider finished outside its wait state");

   a_hops_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_hops_to_gateway != 5'd0 && rsp_hops_to_gateway <= 5'd16))
      else $error("hop report out of range");

   a_accept_starts_work: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (state_ff == ST_U_READ || state_ff == ST_R_READ))
      else $error("accepted beat did not start a scan");

endmodule
